>>> rtl/core/cgc_pkg.sv
`timescale 1ns / 1ps
package cgc_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int ANGLE_FRAC_BITS = 14;

   localparam int DIFF_W       = COORD_WIDTH + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int SUM_W        = PROD_W + 1;
   localparam int NORM_BIT     = 50;
   localparam int XW           = 56;
   localparam int ZW           = 34;
   localparam int SHIFT_W      = 6;
   localparam int CORDIC_STEPS = 31;
   localparam int ANGLE_W      = ANGLE_FRAC_BITS + 2;
   localparam int ROUND_SH     = 30 - ANGLE_FRAC_BITS;
   localparam int NORM_LAT     = 2;

   // csr register indexes
   localparam logic [1:0] CSR_MIN_SEMI_AXIS  = 2'd0;
   localparam logic [1:0] CSR_MAX_ANGLE_DIFF = 2'd1;
   localparam logic [1:0] CSR_MAX_LIMB_ANGLE = 2'd2;

   localparam longint PI_Q30_L      = 64'sd3373259426;
   localparam longint HALF_PI_Q30_L = 64'sd1686629713;
   localparam logic signed [ZW-1:0] PI_Q30      = ZW'(PI_Q30_L);
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(HALF_PI_Q30_L);
   localparam logic signed [ZW-1:0] ROUND_HALF  = ZW'(64'sd1 <<< (ROUND_SH - 1));
   localparam logic [ANGLE_W-1:0] PI_F =
      ANGLE_W'((PI_Q30_L + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH);
   localparam logic [ANGLE_W-1:0] HALF_F =
      ANGLE_W'((HALF_PI_Q30_L + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH);

   typedef enum logic [2:0] {
      REASON_OK     = 3'd0,
      REASON_SMALL  = 3'd1,
      REASON_INSIDE = 3'd2,
      REASON_DIFF   = 3'd3,
      REASON_LIMB   = 3'd4,
      REASON_DEGEN  = 3'd5
   } reason_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] center_x;
      logic signed [COORD_WIDTH-1:0] center_y;
      logic [COORD_WIDTH-1:0]        semi_axis;
      logic signed [COORD_WIDTH-1:0] vertex0_x;
      logic signed [COORD_WIDTH-1:0] vertex0_y;
      logic signed [COORD_WIDTH-1:0] vertex1_x;
      logic signed [COORD_WIDTH-1:0] vertex1_y;
      logic signed [COORD_WIDTH-1:0] apex_x;
      logic signed [COORD_WIDTH-1:0] apex_y;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic [2:0]         reject_reason;
      logic [ANGLE_W-1:0] angle_difference;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      reason_type reason;
   } side_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [ZW-1:0]    z;
      logic                    fixed;
   } vec_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 fixed;
   } cvec_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] r;
      case (idx)
         0: r = ZW'(64'sd843314857);
         1: r = ZW'(64'sd497837829);
         2: r = ZW'(64'sd263043837);
         3: r = ZW'(64'sd133525159);
         4: r = ZW'(64'sd67021687);
         5: r = ZW'(64'sd33543516);
         6: r = ZW'(64'sd16775851);
         7: r = ZW'(64'sd8388437);
         8: r = ZW'(64'sd4194283);
         9: r = ZW'(64'sd2097149);
         default: r = ZW'(64'sd1 <<< (30 - idx));
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/cgc_front.sv
`timescale 1ns / 1ps
module cgc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  cgc_pkg::req_type                in_data,
   input  logic [cgc_pkg::COORD_WIDTH-1:0] min_semi_axis,
   output cgc_pkg::side_type               side_out,
   output cgc_pkg::vec_type                vec0_out,
   output cgc_pkg::vec_type                vec1_out
);
   localparam int DW = cgc_pkg::DIFF_W;
   localparam int PW = cgc_pkg::PROD_W;
   localparam int SW = cgc_pkg::SUM_W;

   // stage 1: differences and cheap flags
   logic                 v1_ff, small_ff, degen_ff;
   logic signed [DW-1:0] ex_ff, ey_ff, nx_ff, ny_ff, l0x_ff, l0y_ff, l1x_ff, l1y_ff;
   logic signed [DW-1:0] dnx_ff, dny_ff;
   logic                 degen_in;

   // stage 2: products
   logic                 v2_ff, small2_ff, degen2_ff;
   logic signed [PW-1:0] ex2_ff, ey2_ff, nx2_ff, ny2_ff;
   logic signed [PW-1:0] d0a_ff, d0b_ff, c0a_ff, c0b_ff, d1a_ff, d1b_ff, c1a_ff, c1b_ff;

   // stage 3: sums
   logic                 v3_ff;
   cgc_pkg::reason_type  reason3_ff, reason3_in;
   logic signed [SW-1:0] dot0_ff, cr0_ff, dot1_ff, cr1_ff;
   logic signed [SW-1:0] de_in, dn_in;

   // stage 4: fold into the right half plane
   cgc_pkg::side_type    side_ff;
   cgc_pkg::vec_type     vec0_ff, vec1_ff;

   function automatic cgc_pkg::vec_type fold(input logic signed [SW-1:0] dot,
                                             input logic signed [SW-1:0] cr);
      cgc_pkg::vec_type     r;
      logic signed [SW-1:0] y;
      y       = (cr < 0) ? -cr : cr;
      r.x     = dot;
      r.y     = y;
      r.z     = '0;
      r.fixed = 1'b0;
      if (y == '0) begin
         r.fixed = 1'b1;
         r.z     = (dot >= 0) ? '0 : cgc_pkg::PI_Q30;
      end else if (dot < 0) begin
         r.x = y;
         r.y = -dot;
         r.z = cgc_pkg::HALF_PI_Q30;
      end
      return r;
   endfunction

   assign degen_in = (in_data.vertex0_x == in_data.vertex1_x &&
                      in_data.vertex0_y == in_data.vertex1_y) ||
                     (in_data.apex_x == in_data.vertex0_x &&
                      in_data.apex_y == in_data.vertex0_y) ||
                     (in_data.apex_x == in_data.vertex1_x &&
                      in_data.apex_y == in_data.vertex1_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         small_ff <= in_data.semi_axis < min_semi_axis;
         degen_ff <= degen_in;
         ex_ff    <= DW'(in_data.center_x) - DW'(in_data.vertex0_x);
         ey_ff    <= DW'(in_data.center_y) - DW'(in_data.vertex0_y);
         nx_ff    <= DW'(in_data.center_x) - DW'(in_data.apex_x);
         ny_ff    <= DW'(in_data.center_y) - DW'(in_data.apex_y);
         l0x_ff   <= DW'(in_data.apex_x) - DW'(in_data.vertex0_x);
         l0y_ff   <= DW'(in_data.apex_y) - DW'(in_data.vertex0_y);
         l1x_ff   <= DW'(in_data.apex_x) - DW'(in_data.vertex1_x);
         l1y_ff   <= DW'(in_data.apex_y) - DW'(in_data.vertex1_y);
         dnx_ff   <= DW'(in_data.vertex1_y) - DW'(in_data.vertex0_y);
         dny_ff   <= DW'(in_data.vertex0_x) - DW'(in_data.vertex1_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         small2_ff <= small_ff;
         degen2_ff <= degen_ff;
         ex2_ff    <= PW'(ex_ff) * PW'(ex_ff);
         ey2_ff    <= PW'(ey_ff) * PW'(ey_ff);
         nx2_ff    <= PW'(nx_ff) * PW'(nx_ff);
         ny2_ff    <= PW'(ny_ff) * PW'(ny_ff);
         d0a_ff    <= PW'(dnx_ff) * PW'(l0x_ff);
         d0b_ff    <= PW'(dny_ff) * PW'(l0y_ff);
         c0a_ff    <= PW'(dnx_ff) * PW'(l0y_ff);
         c0b_ff    <= PW'(dny_ff) * PW'(l0x_ff);
         d1a_ff    <= PW'(dnx_ff) * PW'(l1x_ff);
         d1b_ff    <= PW'(dny_ff) * PW'(l1y_ff);
         c1a_ff    <= PW'(dnx_ff) * PW'(l1y_ff);
         c1b_ff    <= PW'(dny_ff) * PW'(l1x_ff);
      end
   end

   assign de_in = SW'(ex2_ff) + SW'(ey2_ff);
   assign dn_in = SW'(nx2_ff) + SW'(ny2_ff);

   always_comb begin
      if (small2_ff) begin
         reason3_in = cgc_pkg::REASON_SMALL;
      end else if (dn_in < de_in) begin
         reason3_in = cgc_pkg::REASON_INSIDE;
      end else if (degen2_ff) begin
         reason3_in = cgc_pkg::REASON_DEGEN;
      end else begin
         reason3_in = cgc_pkg::REASON_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         reason3_ff <= reason3_in;
         dot0_ff    <= SW'(d0a_ff) + SW'(d0b_ff);
         cr0_ff     <= SW'(c0a_ff) - SW'(c0b_ff);
         dot1_ff    <= SW'(d1a_ff) + SW'(d1b_ff);
         cr1_ff     <= SW'(c1a_ff) - SW'(c1b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff.reason <= reason3_ff;
         vec0_ff        <= fold(dot0_ff, cr0_ff);
         vec1_ff        <= fold(dot1_ff, cr1_ff);
      end
   end

   assign side_out = side_ff;
   assign vec0_out = vec0_ff;
   assign vec1_out = vec1_ff;

endmodule

>>> rtl/core/cgc_norm.sv
`timescale 1ns / 1ps
module cgc_norm (
   input  logic              clock,
   input  logic              en,
   input  cgc_pkg::vec_type  vec_in,
   output cgc_pkg::cvec_type vec_out
);
   localparam int SW = cgc_pkg::SUM_W;
   localparam int XW = cgc_pkg::XW;

   logic [SW-1:0]                 mag;
   logic [cgc_pkg::SHIFT_W-1:0]   msb;
   logic [cgc_pkg::SHIFT_W-1:0]   sh_ff;
   cgc_pkg::vec_type              v_ff;
   cgc_pkg::cvec_type             out_ff;
   logic signed [XW-1:0]          xw, yw;

   // both operands are non-negative here unless the beat is fixed; the larger one sets the shift
   assign mag = v_ff.x | v_ff.y;

   always_comb begin
      msb = '0;
      for (int i = 0; i < SW; i++) begin
         if (vec_in.x[i] | vec_in.y[i]) begin
            msb = cgc_pkg::SHIFT_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff  <= vec_in;
         sh_ff <= cgc_pkg::SHIFT_W'(cgc_pkg::NORM_BIT) - msb;
      end
   end

   assign xw = XW'(v_ff.x);
   assign yw = XW'(v_ff.y);

   always_ff @(posedge clock) begin
      if (en) begin
         // zero magnitude only happens on a fixed-angle beat; shift is moot
         out_ff.x     <= (mag == '0) ? xw : (xw <<< sh_ff);
         out_ff.y     <= (mag == '0) ? yw : (yw <<< sh_ff);
         out_ff.z     <= v_ff.z;
         out_ff.fixed <= v_ff.fixed;
      end
   end

   assign vec_out = out_ff;

endmodule

>>> rtl/core/cgc_cordic.sv
`timescale 1ns / 1ps
module cgc_cordic (
   input  logic                           clock,
   input  logic                           en,
   input  cgc_pkg::cvec_type              vec_in,
   output logic signed [cgc_pkg::ZW-1:0]  z_out
);
   localparam int STEPS = cgc_pkg::CORDIC_STEPS;

   cgc_pkg::cvec_type st_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      cgc_pkg::cvec_type cur, nxt;

      if (i == 0) begin : g_first
         assign cur = vec_in;
      end else begin : g_next
         assign cur = st_ff[i-1];
      end

      always_comb begin
         nxt = cur;
         if (!cur.fixed) begin
            if (cur.y >= 0) begin
               nxt.x = cur.x + (cur.y >>> i);
               nxt.y = cur.y - (cur.x >>> i);
               nxt.z = cur.z + cgc_pkg::atan_q30(i);
            end else begin
               nxt.x = cur.x - (cur.y >>> i);
               nxt.y = cur.y + (cur.x >>> i);
               nxt.z = cur.z - cgc_pkg::atan_q30(i);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i] <= nxt;
         end
      end
   end

   assign z_out = st_ff[STEPS-1].z;

endmodule

>>> rtl/core/cone_geometry_check_core.sv
`timescale 1ns / 1ps
// Geometry test for one cone candidate (ellipse center, semi-axis, two
// vertices, apex). Every beat gets exactly one result beat. The block is a
// pipeline that takes a new beat every clock unless it stalls: four front
// stages (differences, products, sums, half-plane fold), two normalize
// stages, one stage per CORDIC iteration (31), three back stages (round,
// fold and difference, threshold check into the output register), 40
// register stages in all. The two limb angles run in parallel CORDIC
// lanes. The whole pipeline advances as one unit and holds only while a
// finished result sits in the output register and the sink stalls, so
// req_stall follows rsp_stall in that case. Thresholds on the csr port are
// sampled as beats pass and should be changed only with the pipeline
// empty. Index 0 min_semi_axis, 1 max_angle_difference, 2 max_limb_angle;
// other indexes are dropped.
module cone_geometry_check_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cgc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cgc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   localparam int AW  = cgc_pkg::ANGLE_W;
   localparam int ZW  = cgc_pkg::ZW;
   localparam int DLY = cgc_pkg::NORM_LAT + cgc_pkg::CORDIC_STEPS;

   logic                 en;
   logic [15:0]          min_semi_ff, max_diff_ff;
   logic [14:0]          max_limb_ff;

   cgc_pkg::side_type    side_f;
   cgc_pkg::vec_type     vec0_f, vec1_f;
   cgc_pkg::cvec_type    vec0_n, vec1_n;
   logic signed [ZW-1:0] z0, z1;

   cgc_pkg::side_type    side_ff [DLY];

   cgc_pkg::side_type    p1_side_ff, p2_side_ff;
   logic [AW-1:0]        a0_ff, a1_ff, a0_in, a1_in;
   logic [AW-1:0]        diff_ff, f0_ff, f1_ff;

   logic                 rsp_valid_ff;
   cgc_pkg::rsp_type     rsp_ff, rsp_in;
   cgc_pkg::reason_type  reason_in;

   // advance everything unless a finished beat is stuck at the output
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_semi_ff <= 16'd160;
         max_diff_ff <= 16'd4915;
         max_limb_ff <= 15'd21299;
      end else if (csr_we) begin
         case (csr_index)
            cgc_pkg::CSR_MIN_SEMI_AXIS:  min_semi_ff <= csr_wdata;
            cgc_pkg::CSR_MAX_ANGLE_DIFF: max_diff_ff <= csr_wdata;
            cgc_pkg::CSR_MAX_LIMB_ANGLE: max_limb_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   cgc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_valid),
      .in_data       (req_data),
      .min_semi_axis (min_semi_ff),
      .side_out      (side_f),
      .vec0_out      (vec0_f),
      .vec1_out      (vec1_f)
   );

   cgc_norm u_norm0 (.clock(clock), .en(en), .vec_in(vec0_f), .vec_out(vec0_n));
   cgc_norm u_norm1 (.clock(clock), .en(en), .vec_in(vec1_f), .vec_out(vec1_n));

   cgc_cordic u_cordic0 (.clock(clock), .en(en), .vec_in(vec0_n), .z_out(z0));
   cgc_cordic u_cordic1 (.clock(clock), .en(en), .vec_in(vec1_n), .z_out(z1));

   // carry valid and early reason alongside the angle lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DLY; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= side_f;
         for (int i = 1; i < DLY; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // clamp to [0, pi] and round half up to the output angle step
   function automatic logic [AW-1:0] to_angle(input logic signed [ZW-1:0] z);
      logic signed [ZW-1:0] zc;
      logic signed [ZW-1:0] zr;
      zc = z;
      if (z < 0) begin
         zc = '0;
      end else if (z > cgc_pkg::PI_Q30) begin
         zc = cgc_pkg::PI_Q30;
      end
      zr = zc + cgc_pkg::ROUND_HALF;
      return zr[cgc_pkg::ROUND_SH +: AW];
   endfunction

   assign a0_in = to_angle(z0);
   assign a1_in = to_angle(z1);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_side_ff.valid <= 1'b0;
         p2_side_ff.valid <= 1'b0;
      end else if (en) begin
         p1_side_ff.valid <= side_ff[DLY-1].valid;
         p2_side_ff.valid <= p1_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff.reason <= side_ff[DLY-1].reason;
         a0_ff             <= a0_in;
         a1_ff             <= a1_in;
         p2_side_ff.reason <= p1_side_ff.reason;
         diff_ff           <= (a0_ff > a1_ff) ? (a0_ff - a1_ff) : (a1_ff - a0_ff);
         f0_ff             <= (a0_ff > cgc_pkg::HALF_F) ? (cgc_pkg::PI_F - a0_ff) : a0_ff;
         f1_ff             <= (a1_ff > cgc_pkg::HALF_F) ? (cgc_pkg::PI_F - a1_ff) : a1_ff;
      end
   end

   always_comb begin
      reason_in = p2_side_ff.reason;
      if (p2_side_ff.reason == cgc_pkg::REASON_OK) begin
         if (diff_ff > max_diff_ff) begin
            reason_in = cgc_pkg::REASON_DIFF;
         end else if (f0_ff > AW'(max_limb_ff) || f1_ff > AW'(max_limb_ff)) begin
            reason_in = cgc_pkg::REASON_LIMB;
         end
      end
      rsp_in.accepted         = (reason_in == cgc_pkg::REASON_OK);
      rsp_in.reject_reason    = reason_in;
      // drop the difference on early rejects
      rsp_in.angle_difference = (p2_side_ff.reason == cgc_pkg::REASON_OK) ? diff_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= p2_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_accept_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.accepted ==
                     (rsp_data.reject_reason == cgc_pkg::REASON_OK)))
      else $error("accepted flag disagrees with reject reason");

   a_early_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.reject_reason == cgc_pkg::REASON_SMALL ||
                    rsp_data.reject_reason == cgc_pkg::REASON_INSIDE ||
                    rsp_data.reject_reason == cgc_pkg::REASON_DEGEN)
      |-> rsp_data.angle_difference == '0)
      else $error("early reject carries a nonzero angle difference");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while the output is blocked");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

   // csr index that maps to no register; writes to it are dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam int     PIPE_LATENCY = 40;
   localparam int     CYCLE_LIMIT  = 400000;
   localparam int     HOLD_CYCLES  = 300;
   localparam longint NORM_TOP     = 64'sd1 <<< 50;

   // arctangent of 2^-i at 2^-30 radian
   localparam longint ARC_STEP [31] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149,
      1048576, 524288, 262144, 131072, 65536,
      32768, 16384, 8192, 4096, 2048,
      1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2, 1};

   typedef struct {
      cgc_pkg::req_type item;
      bit               typed;
      cgc_pkg::rsp_type want;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   cgc_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   cgc_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [15:0]      csr_wdata;

   // thresholds as the block should currently hold them
   logic [15:0] min_semi_axis_q;
   logic [15:0] max_angle_diff_q;
   logic [14:0] max_limb_angle_q;

   cgc_pkg::rsp_type pending_verdicts[$];
   int          mismatch_count;
   int          beats_sent;
   int          verdicts_seen;
   int          accept_count;
   int          reason_hits[6];
   int          cycle_count;
   bit          quiet;
   bit          hold_request;
   bit          hold_done;

   cone_geometry_check_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Angle in [0, pi] between two vectors at 2^-30 radian: vectoring CORDIC on
   // (dot, |cross|), pre-rotated by pi/2 when the dot product is negative.
   function automatic longint limb_angle_q30(longint ux, longint uy, longint vx, longint vy);
      longint x, y, z, cr, dx, dy, t;
      x = ux * vx + uy * vy;
      cr = ux * vy - uy * vx;
      y = (cr < 0) ? -cr : cr;
      z = 0;
      if (y == 0) return (x >= 0) ? 64'sd0 : cgc_pkg::PI_Q30_L;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         z = cgc_pkg::HALF_PI_Q30_L;
      end
      while (x < NORM_TOP && y < NORM_TOP) begin
         x = x <<< 1;
         y = y <<< 1;
      end
      for (int i = 0; i < 31; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx;
            y -= dy;
            z += ARC_STEP[i];
         end else begin
            x -= dx;
            y += dy;
            z -= ARC_STEP[i];
         end
      end
      if (z < 0) z = 0;
      if (z > cgc_pkg::PI_Q30_L) z = cgc_pkg::PI_Q30_L;
      return z;
   endfunction

   function automatic longint round_angle(longint q30);
      return (q30 + (64'sd1 <<< (cgc_pkg::ROUND_SH - 1))) >>> cgc_pkg::ROUND_SH;
   endfunction

   function automatic cgc_pkg::rsp_type judge_candidate(cgc_pkg::req_type c);
      longint cx, cy, v0x, v0y, v1x, v1y, px, py;
      longint l0x, l0y, l1x, l1y, a0, a1, diff, pi_f, half_f;
      cgc_pkg::reason_type reason;
      cgc_pkg::rsp_type r;
      cx = c.center_x;   cy = c.center_y;
      v0x = c.vertex0_x; v0y = c.vertex0_y;
      v1x = c.vertex1_x; v1y = c.vertex1_y;
      px = c.apex_x;     py = c.apex_y;
      l0x = px - v0x;    l0y = py - v0y;
      l1x = px - v1x;    l1y = py - v1y;
      pi_f = round_angle(cgc_pkg::PI_Q30_L);
      half_f = round_angle(cgc_pkg::HALF_PI_Q30_L);
      reason = cgc_pkg::REASON_OK;
      diff = 0;
      if (longint'(c.semi_axis) < longint'(min_semi_axis_q)) begin
         reason = cgc_pkg::REASON_SMALL;
      end else if ((cx-px)*(cx-px) + (cy-py)*(cy-py) <
                   (cx-v0x)*(cx-v0x) + (cy-v0y)*(cy-v0y)) begin
         reason = cgc_pkg::REASON_INSIDE;
      end else if ((v0x == v1x && v0y == v1y) || (l0x == 0 && l0y == 0)
                   || (l1x == 0 && l1y == 0)) begin
         reason = cgc_pkg::REASON_DEGEN;
      end else begin
         // normal: vertex difference turned by +90 degrees
         a0 = round_angle(limb_angle_q30(-(v0y - v1y), v0x - v1x, l0x, l0y));
         a1 = round_angle(limb_angle_q30(-(v0y - v1y), v0x - v1x, l1x, l1y));
         diff = (a0 > a1) ? a0 - a1 : a1 - a0;
         if (a0 > half_f) a0 = pi_f - a0;
         if (a1 > half_f) a1 = pi_f - a1;
         if (diff > longint'(max_angle_diff_q))
            reason = cgc_pkg::REASON_DIFF;
         else if (a0 > longint'(max_limb_angle_q) || a1 > longint'(max_limb_angle_q))
            reason = cgc_pkg::REASON_LIMB;
      end
      r.accepted = (reason == cgc_pkg::REASON_OK);
      r.reject_reason = reason;
      r.angle_difference = diff[cgc_pkg::ANGLE_W-1:0];
      return r;
   endfunction

   function automatic cgc_pkg::req_type make_candidate(int cx, int cy, int a, int v0x,
                                                       int v0y, int v1x, int v1y,
                                                       int px, int py);
      cgc_pkg::req_type c;
      c.center_x = 16'(cx);   c.center_y = 16'(cy);   c.semi_axis = 16'(a);
      c.vertex0_x = 16'(v0x); c.vertex0_y = 16'(v0y);
      c.vertex1_x = 16'(v1x); c.vertex1_y = 16'(v1y);
      c.apex_x = 16'(px);     c.apex_y = 16'(py);
      return c;
   endfunction

   // Mostly well-formed cones: vertices symmetric about the center, apex out
   // along the normal with jitter. The rest is raw noise or broken geometry.
   function automatic cgc_pkg::req_type random_candidate();
      cgc_pkg::req_type c;
      logic [159:0]     noise;
      int cx, cy, dx, dy, k, mode;
      mode = $urandom_range(0, 9);
      if (mode == 7) begin
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
         c = noise[$bits(cgc_pkg::req_type)-1:0];
         return c;
      end
      cx = $signed($urandom_range(0, 16000)) - 8000;
      cy = $signed($urandom_range(0, 16000)) - 8000;
      dx = $signed($urandom_range(0, 4000)) - 2000;
      dy = $signed($urandom_range(0, 4000)) - 2000;
      k  = $urandom_range(1, 4);
      if ($urandom_range(0, 1)) k = -k;
      c = make_candidate(cx, cy, 0, cx + dx, cy + dy, cx - dx, cy - dy,
                         cx - k * dy + $signed($urandom_range(0, 1200)) - 600,
                         cy + k * dx + $signed($urandom_range(0, 1200)) - 600);
      if ($urandom_range(0, 7) == 0)
         c.semi_axis = 16'($urandom);
      else
         c.semi_axis = 16'($urandom_range(int'(min_semi_axis_q), 65535));
      if (mode == 8) begin
         case ($urandom_range(0, 2))
            0: {c.vertex1_x, c.vertex1_y} = {c.vertex0_x, c.vertex0_y};
            1: {c.apex_x, c.apex_y} = {c.vertex0_x, c.vertex0_y};
            default: {c.apex_x, c.apex_y} = {c.vertex1_x, c.vertex1_y};
         endcase
      end else if (mode == 9) begin
         c.apex_x = 16'(cx + $signed($urandom_range(0, 200)) - 100);
         c.apex_y = 16'(cy + $signed($urandom_range(0, 200)) - 100);
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at beat %0d: %s got %0d, want %0d", verdicts_seen, what, got, want);
      mismatch_count++;
   endtask

   // Offer one beat and hold it until the block takes it; the verdict is
   // queued at the accepting edge.
   task automatic send_candidate(cgc_pkg::req_type c, bit typed, cgc_pkg::rsp_type want);
      int gap;
      gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(typed ? want : judge_candidate(c));
      beats_sent++;
   endtask

   task automatic write_threshold(logic [1:0] index, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         cgc_pkg::CSR_MIN_SEMI_AXIS:  min_semi_axis_q  = value;
         cgc_pkg::CSR_MAX_ANGLE_DIFF: max_angle_diff_q = value;
         cgc_pkg::CSR_MAX_LIMB_ANGLE: max_limb_angle_q = value[14:0];
         default: ;
      endcase
   endtask

   // Wait for every verdict, then for the pipeline to run dry.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_thresholds(int min_a, int max_d, int max_l);
      write_threshold(cgc_pkg::CSR_MIN_SEMI_AXIS, 16'(min_a));
      write_threshold(cgc_pkg::CSR_MAX_ANGLE_DIFF, 16'(max_d));
      write_threshold(cgc_pkg::CSR_MAX_LIMB_ANGLE, 16'(max_l));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: check every accepted verdict against the oldest prediction.
   always @(posedge clock) begin
      cgc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected verdict, queue depth", 0, 1);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.accepted !== want.accepted)
               report_mismatch("accepted", int'(rsp_data.accepted), int'(want.accepted));
            if (rsp_data.reject_reason !== want.reject_reason)
               report_mismatch("reject_reason", int'(rsp_data.reject_reason),
                               int'(want.reject_reason));
            if (rsp_data.angle_difference !== want.angle_difference)
               report_mismatch("angle_difference", int'(rsp_data.angle_difference),
                               int'(want.angle_difference));
            if (want.accepted) accept_count++;
            if (want.reject_reason < 6) reason_hits[want.reject_reason]++;
         end
         verdicts_seen++;
      end
   end

   // Result side backpressure: random bursts, one long hold on request.
   initial begin
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 0;
            hold_done = 1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(1, 4) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      stim_row_type     directed[$];
      stim_row_type     row;
      cgc_pkg::rsp_type typed_verdict;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = cgc_pkg::CSR_MIN_SEMI_AXIS;
      csr_wdata = '0;
      quiet = 0;
      hold_request = 0;
      hold_done = 0;
      mismatch_count = 0;
      beats_sent = 0;
      verdicts_seen = 0;
      accept_count = 0;
      cycle_count = 0;
      min_semi_axis_q = 16'd160;
      max_angle_diff_q = 16'd4915;
      max_limb_angle_q = 15'd21299;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at reset thresholds. Typed verdicts: early rejects and
      // a symmetric cone with both limbs at the same angle.
      typed_verdict = '{1'b0, cgc_pkg::REASON_SMALL, '0};
      directed.push_back('{make_candidate(0, 0, 0, 320, 0, -320, 0, 0, 1600), 1, typed_verdict});
      directed.push_back('{make_candidate(0, 0, 159, 320, 0, -320, 0, 0, 1600), 1, typed_verdict});
      typed_verdict = '{1'b0, cgc_pkg::REASON_INSIDE, '0};
      directed.push_back('{make_candidate(0, 0, 1000, 100, 0, -100, 0, 10, 0), 1, typed_verdict});
      typed_verdict = '{1'b0, cgc_pkg::REASON_DEGEN, '0};
      directed.push_back('{make_candidate(0, 0, 1000, 100, 0, 100, 0, 0, 500), 1, typed_verdict});
      directed.push_back('{make_candidate(0, 0, 1000, 100, 0, -100, 0, 100, 0), 1, typed_verdict});
      directed.push_back('{make_candidate(0, 0, 1000, 100, 0, -100, 0, -100, 0), 1,
                           typed_verdict});
      typed_verdict = '{1'b1, cgc_pkg::REASON_OK, '0};
      directed.push_back('{make_candidate(0, 0, 160, 320, 0, -320, 0, 0, 1600), 1, typed_verdict});
      directed.push_back('{make_candidate(0, 0, 65535, 320, 0, -320, 0, 0, -1600), 1,
                           typed_verdict});
      // predicted rows: extremes, limb and difference failures, collinear limbs
      directed.push_back('{make_candidate(-32768, -32768, 65535, 32767, 32767, -32768, 32767,
                                          32767, -32768), 0, '0});
      directed.push_back('{make_candidate(32767, 32767, 65535, -32768, -32768, 32767, -32768,
                                          -32768, 32767), 0, '0});
      directed.push_back('{make_candidate(0, 0, 500, 320, 0, -320, 0, 3000, 400), 0, '0});
      directed.push_back('{make_candidate(0, 0, 500, 320, 0, -320, 0, 2000, 2000), 0, '0});
      directed.push_back('{make_candidate(0, 0, 500, 320, 0, -320, 0, 400, 0), 0, '0});
      directed.push_back('{make_candidate(0, 0, 500, 320, 0, -320, 0, -3000, 0), 0, '0});
      directed.push_back('{make_candidate(0, 0, 500, 320, 0, -320, 0, 320, 3000), 0, '0});
      directed.push_back('{make_candidate(0, 0, 500, 320, 0, -320, 0, 0, -32768), 0, '0});
      directed.push_back('{make_candidate(0, 0, 500, 320, 100, -320, -100, -50, 2000), 0, '0});
      foreach (directed[i]) begin
         row = directed[i];
         send_candidate(row.item, row.typed, row.want);
      end
      drain_pipeline();

      // Random phases under different thresholds, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ;
            1: set_thresholds(0, 0, 0);
            2: set_thresholds(65535, 51472, 25736);
            3: begin
               write_threshold(CSR_UNUSED, 16'($urandom));
               set_thresholds($urandom_range(0, 400), $urandom_range(0, 65535),
                              $urandom_range(0, 32767));
            end
            4: set_thresholds(1, 20000, 25000);
            default: begin
               set_thresholds(160, $urandom_range(2000, 8000), $urandom_range(15000, 25736));
               quiet = 1;
            end
         endcase
         for (int n = 0; n < 250; n++) begin
            // hold the result side off while beats keep coming
            if (phase == 3 && n == 20) hold_request = 1;
            send_candidate(random_candidate(), 0, '0);
         end
         drain_pipeline();
      end

      $display("%0d candidates checked over six threshold settings, %0d accepted%s",
               verdicts_seen, accept_count,
               hold_done ? ", one long output hold included" : "");
      $display("rejects small %0d, inside %0d, degenerate %0d, difference %0d, limb %0d",
               reason_hits[cgc_pkg::REASON_SMALL], reason_hits[cgc_pkg::REASON_INSIDE],
               reason_hits[cgc_pkg::REASON_DEGEN], reason_hits[cgc_pkg::REASON_DIFF],
               reason_hits[cgc_pkg::REASON_LIMB]);
      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
